### hw/rtl/tsb_pkg.sv
package tsb_pkg;

  localparam int SLOT_FIELD_W = 4;
  localparam int PERIOD_W = 31;
  localparam int ELAPSED_W = 24;
  localparam int REM_W = 33;
  localparam int COUNT_W = 32;
  localparam int MAX_RES = 16;
  localparam int CNT_W = $clog2(MAX_RES + 1);

  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_UPDATE = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_QUERY = 3'd4;

  localparam logic [1:0] KIND_ACK = 2'd0;
  localparam logic [1:0] KIND_FIRED = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [1:0] STAT_NEVER = 2'd0;
  localparam logic [1:0] STAT_RUN = 2'd1;
  localparam logic [1:0] STAT_STOP = 2'd2;

  localparam logic signed [REM_W:0] REM_FLOOR = -34'sd16777215;

  typedef struct packed {
    logic [2:0]              opcode;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [PERIOD_W-1:0]     period;
    logic                    repeat_req;
    logic [ELAPSED_W-1:0]    elapsed;
  } req_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [SLOT_FIELD_W-1:0] slot_out;
    logic [1:0]              slot_status;
    logic [COUNT_W-1:0]      elapsed_count;
    logic                    last;
  } rsp_t;

  typedef struct packed {
    logic                    armed;
    logic                    mode;
    logic [1:0]              status;
    logic [PERIOD_W-1:0]     period;
    logic signed [REM_W-1:0] remaining;
  } entry_t;

  typedef struct packed {
    logic               fire;
    logic [COUNT_W-1:0] count;
    entry_t             entry;
  } alu_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_FLUSH
  } state_t;

endpackage

### hw/rtl/tsb_store.sv
module tsb_store #(
  parameter int SLOTS = 16,
  parameter int SLOT_W = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic [SLOT_W-1:0]  rd_addr,
  output tsb_pkg::entry_t    rd_entry,
  input  logic               wr_en,
  input  logic [SLOT_W-1:0]  wr_addr,
  input  tsb_pkg::entry_t    wr_entry
);
  import tsb_pkg::*;

  entry_t mem [SLOTS];
  logic [SLOTS-1:0] valid;
  entry_t rdata;
  logic rvalid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rvalid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvalid <= valid[rd_addr];
      end
    end
  end

  // A slot that was never written reads as its reset value of all zero.
  assign rd_entry = rvalid ? rdata : '0;

endmodule

### hw/rtl/tsb_alu.sv
module tsb_alu (
  input  tsb_pkg::req_t     item,
  input  tsb_pkg::entry_t   entry_in,
  output tsb_pkg::alu_res_t res
);
  import tsb_pkg::*;

  logic signed [REM_W-1:0] rem_src;
  logic signed [REM_W:0] opa;
  logic signed [REM_W:0] opb;
  logic signed [REM_W:0] diff;
  logic signed [REM_W:0] rnew;
  logic [PERIOD_W-1:0] per_sel;

  always_comb begin
    rem_src = (item.opcode == OP_INSERT) ? '0 : entry_in.remaining;
    per_sel = (item.opcode == OP_QUERY) ? entry_in.period : item.period;
    if (item.opcode == OP_TICK) begin
      opa = {rem_src[REM_W-1], rem_src};
      opb = {{(REM_W + 1 - ELAPSED_W){1'b0}}, item.elapsed};
    end else begin
      opa = {{(REM_W + 1 - PERIOD_W){1'b0}}, per_sel};
      opb = {rem_src[REM_W-1], rem_src};
    end
    diff = opa - opb;
    rnew = (diff < REM_FLOOR) ? REM_FLOOR : diff;

    res.entry = entry_in;
    res.fire = 1'b0;
    res.count = '0;

    case (item.opcode)
      OP_TICK: begin
        if (entry_in.armed) begin
          if (rnew[REM_W] || (rnew == '0)) begin
            res.fire = 1'b1;
            if (entry_in.mode) begin
              res.entry.remaining = {2'b00, entry_in.period};
            end else begin
              res.entry.remaining = rnew[REM_W-1:0];
              res.entry.armed = 1'b0;
              res.entry.status = STAT_STOP;
            end
          end else begin
            res.entry.remaining = rnew[REM_W-1:0];
          end
        end
      end
      OP_INSERT, OP_UPDATE: begin
        res.entry.period = item.period;
        res.entry.remaining = diff[REM_W] ? {2'b00, item.period} : rem_src;
        res.entry.mode = item.repeat_req;
        res.entry.status = STAT_RUN;
        res.entry.armed = 1'b1;
      end
      OP_DELETE: begin
        if (entry_in.armed) begin
          res.entry.armed = 1'b0;
          res.entry.status = STAT_STOP;
        end
      end
      OP_QUERY: begin
        res.count = (diff[REM_W] || (diff == '0)) ? '0 : diff[COUNT_W-1:0];
      end
      default: begin
      end
    endcase
  end

endmodule

### hw/rtl/tsb_ctrl.sv
module tsb_ctrl #(
  parameter int SLOTS = 16,
  parameter int SLOT_W = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  tsb_pkg::req_t      req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output tsb_pkg::rsp_t      rsp,
  output tsb_pkg::req_t      item,
  input  tsb_pkg::alu_res_t  alu_res,
  output logic               rd_en,
  output logic [SLOT_W-1:0]  rd_addr,
  output logic               wr_en,
  output logic [SLOT_W-1:0]  wr_addr,
  output tsb_pkg::entry_t    wr_entry
);
  import tsb_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

  state_t state;
  state_t state_next;
  req_t item_next;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] idx_next;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] n_next;
  rsp_t pend;
  rsp_t pend_next;
  logic push;
  rsp_t push_data;
  logic out_free;
  logic is_tick;
  logic ok;
  logic report;
  logic modifies;

  assign is_tick = (item.opcode == OP_TICK);
  assign ok = (32'(item.slot) < SLOTS);
  assign modifies = (item.opcode == OP_INSERT) || (item.opcode == OP_UPDATE) ||
                    (item.opcode == OP_DELETE);
  assign out_free = !rsp_valid || !rsp_stall;
  assign report = alu_res.fire && (n < CNT_W'(MAX_RES));
  assign rd_addr = is_tick ? idx : SLOT_W'(item.slot);
  assign wr_addr = rd_addr;
  assign wr_entry = alu_res.entry;
  assign req_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      n <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      n <= n_next;
      if (push) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    item <= item_next;
    idx <= idx_next;
    pend <= pend_next;
    if (push) begin
      rsp <= push_data;
    end
  end

  always_comb begin
    state_next = state;
    item_next = item;
    idx_next = idx;
    n_next = n;
    pend_next = pend;
    rd_en = 1'b0;
    wr_en = 1'b0;
    push = 1'b0;
    push_data = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          item_next = req;
          idx_next = '0;
          n_next = '0;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        rd_en = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (is_tick) begin
          // The held fired result goes out only once a later one is known or the scan has ended.
          if (!(report && (n != '0) && !out_free)) begin
            wr_en = 1'b1;
            if (report) begin
              if (n != '0) begin
                push = 1'b1;
                push_data = pend;
              end
              pend_next = '{kind: KIND_FIRED,
                            slot_out: SLOT_FIELD_W'(idx),
                            slot_status: alu_res.entry.status,
                            elapsed_count: '0,
                            last: 1'b0};
              n_next = n + CNT_W'(1);
            end
            if (idx == LAST_IDX) begin
              state_next = ST_FLUSH;
            end else begin
              idx_next = idx + SLOT_W'(1);
              state_next = ST_READ;
            end
          end
        end else if (out_free) begin
          wr_en = ok && modifies;
          push = 1'b1;
          push_data.kind = (item.opcode == OP_QUERY) ? KIND_QUERY : KIND_ACK;
          push_data.slot_out = item.slot;
          push_data.slot_status = ok ? alu_res.entry.status : STAT_NEVER;
          push_data.elapsed_count = ok ? alu_res.count : '0;
          push_data.last = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          push = 1'b1;
          if (n != '0) begin
            push_data = pend;
          end else begin
            push_data.kind = KIND_ACK;
          end
          push_data.last = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("Result register overwritten while a transfer was pending.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    n <= CNT_W'(MAX_RES))
    else $error("Reported result count exceeds its limit.");

  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == ST_READ))
    else $error("An accepted transfer did not start a slot read.");

  a_flush_tick: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> is_tick)
    else $error("Final tick result pending for an operation that is not a tick.");

  a_write_exec: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ((state == ST_EXEC) && $past(rd_en || (state == ST_EXEC))))
    else $error("Slot write without a preceding slot read.");

endmodule

### hw/rtl/timer_slot_bank_unit.sv
// Insert, update, delete, query and unknown opcodes pass through a slot read and an execute
// step that loads the result once the result register is free, and the next transfer is
// accepted in the cycle after the result is loaded. A tick reads and rewrites each slot in
// turn through one shared subtract unit, then loads its final result in a flush step; the
// next transfer follows in the cycle after that, and a stalled result register can hold back both.
// Reset clears the per-slot valid bits at once; no clearing pass follows.
module timer_slot_bank_unit #(
  parameter int SLOTS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  tsb_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output tsb_pkg::rsp_t  rsp
);
  import tsb_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  req_t item;
  alu_res_t alu_res;
  entry_t rd_entry;
  entry_t wr_entry;
  logic rd_en;
  logic wr_en;
  logic [SLOT_W-1:0] rd_addr;
  logic [SLOT_W-1:0] wr_addr;

  tsb_store #(
    .SLOTS(SLOTS),
    .SLOT_W(SLOT_W)
  ) u_store (
    .clk(clk),
    .rst(rst),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_entry(rd_entry),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_entry(wr_entry)
  );

  tsb_alu u_alu (
    .item(item),
    .entry_in(rd_entry),
    .res(alu_res)
  );

  tsb_ctrl #(
    .SLOTS(SLOTS),
    .SLOT_W(SLOT_W)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .item(item),
    .alu_res(alu_res),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_entry(wr_entry)
  );

endmodule

### dv/timer_slot_bank_checker.sv
`timescale 1ns / 100ps

module timer_slot_bank_checker
  import tsb_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   mismatches,
  output int   awaited
);

  logic                    armed_q  [SLOTS];
  logic                    loop_q   [SLOTS];
  logic [1:0]              status_q [SLOTS];
  logic [PERIOD_W-1:0]     period_q [SLOTS];
  logic signed [REM_W-1:0] remain_q [SLOTS];

  rsp_t bank_rsps[$];

  task automatic arm_slot(input req_t c);
    period_q[c.slot] = c.period;
    if (longint'(remain_q[c.slot]) > longint'(c.period)) begin
      remain_q[c.slot] = REM_W'(longint'(c.period));
    end
    loop_q[c.slot] = c.repeat_req;
    status_q[c.slot] = STAT_RUN;
    armed_q[c.slot] = 1'b1;
  endtask

  task automatic predict_command(input req_t c);
    rsp_t   r;
    int     fired;
    longint diff;
    longint floor_v;
    logic   ok;
    floor_v = longint'(REM_FLOOR);
    ok = int'(c.slot) < SLOTS;
    r = '0;
    r.slot_out = c.slot;
    r.last = 1'b1;
    if (c.opcode == OP_TICK) begin
      fired = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (armed_q[i]) begin
          diff = longint'(remain_q[i]) - longint'(c.elapsed);
          remain_q[i] = REM_W'((diff < floor_v) ? floor_v : diff);
        end
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (armed_q[i] && longint'(remain_q[i]) <= 0) begin
          if (loop_q[i]) begin
            remain_q[i] = REM_W'(longint'(period_q[i]));
          end else begin
            armed_q[i] = 1'b0;
            status_q[i] = STAT_STOP;
          end
          if (fired < MAX_RES) begin
            r = '0;
            r.kind = KIND_FIRED;
            r.slot_out = SLOT_FIELD_W'(i);
            r.slot_status = status_q[i];
            bank_rsps.push_back(r);
            fired++;
          end
        end
      end
      if (fired == 0) begin
        r = '0;
        r.kind = KIND_ACK;
        r.last = 1'b1;
      end else begin
        r = bank_rsps.pop_back();
        r.last = 1'b1;
      end
      bank_rsps.push_back(r);
    end else if (c.opcode == OP_QUERY) begin
      r.kind = KIND_QUERY;
      if (ok) begin
        diff = longint'(period_q[c.slot]) - longint'(remain_q[c.slot]);
        r.slot_status = status_q[c.slot];
        r.elapsed_count = (diff > 0) ? COUNT_W'(diff) : '0;
      end
      bank_rsps.push_back(r);
    end else begin
      if (ok) begin
        case (c.opcode)
          OP_INSERT: begin
            remain_q[c.slot] = '0;
            arm_slot(c);
          end
          OP_UPDATE: begin
            arm_slot(c);
          end
          OP_DELETE: begin
            if (armed_q[c.slot]) begin
              armed_q[c.slot] = 1'b0;
              status_q[c.slot] = STAT_STOP;
            end
          end
          default: begin
          end
        endcase
        r.slot_status = status_q[c.slot];
      end
      r.kind = KIND_ACK;
      bank_rsps.push_back(r);
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_rsp(input rsp_t got);
    rsp_t want;
    if (bank_rsps.size() == 0) begin
      $error("Response with none outstanding: kind %0h, slot_out %0h", got.kind,
             got.slot_out);
      mismatches++;
    end else begin
      want = bank_rsps.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("slot_out", want.slot_out, got.slot_out);
      compare_field("slot_status", want.slot_status, got.slot_status);
      compare_field("elapsed_count", want.elapsed_count, got.elapsed_count);
      compare_field("last", want.last, got.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        armed_q[i] = 1'b0;
        loop_q[i] = 1'b0;
        status_q[i] = STAT_NEVER;
        period_q[i] = '0;
        remain_q[i] = '0;
      end
      bank_rsps.delete();
      mismatches = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        check_rsp(rsp);
      end
      if (req_valid && !req_stall) begin
        predict_command(req);
      end
    end
    awaited = bank_rsps.size();
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tsb_pkg::*;

  localparam int SLOTS = 16;
  localparam int HOLD_CYCLES = 400;
  localparam logic [2:0] OP_RSVD_A = 3'd5;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  logic tx_gaps = 1'b0;
  logic rx_gaps = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   mismatches;
  int   awaited;

  always #10 clk = ~clk;

  timer_slot_bank_unit #(
    .SLOTS(SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  timer_slot_bank_checker #(
    .SLOTS(SLOTS)
  ) bank_check (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .mismatches(mismatches),
    .awaited   (awaited)
  );

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_stall <= rx_gaps && ($urandom_range(0, 99) < 22);
    end
  end

  function automatic req_t cmd(input logic [2:0] op, input logic [SLOT_FIELD_W-1:0] s,
                               input logic [PERIOD_W-1:0] p, input logic rep,
                               input logic [ELAPSED_W-1:0] el);
    req_t c;
    c.opcode = op;
    c.slot = s;
    c.period = p;
    c.repeat_req = rep;
    c.elapsed = el;
    return c;
  endfunction

  function automatic req_t random_cmd();
    req_t c;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) c.opcode = OP_TICK;
    else if (pick < 50) c.opcode = OP_INSERT;
    else if (pick < 65) c.opcode = OP_UPDATE;
    else if (pick < 75) c.opcode = OP_DELETE;
    else if (pick < 95) c.opcode = OP_QUERY;
    else c.opcode = OP_RSVD_A + 3'($urandom_range(0, 2));
    c.slot = SLOT_FIELD_W'($urandom_range(0, SLOTS - 1));
    c.repeat_req = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 50) c.period = PERIOD_W'($urandom_range(0, 5000));
    else if (pick < 80) c.period = PERIOD_W'($urandom_range(0, 1 << ELAPSED_W));
    else c.period = PERIOD_W'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 60) c.elapsed = ELAPSED_W'($urandom_range(0, 3000));
    else if (pick < 85) c.elapsed = ELAPSED_W'($urandom());
    else c.elapsed = $urandom_range(0, 1) ? '1 : '0;
    return c;
  endfunction

  task automatic offer(input req_t item);
    while (tx_gaps && $urandom_range(0, 99) < 22) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    wait (awaited == 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer(cmd(OP_TICK, 0, 0, 0, 0));
    offer(cmd(OP_QUERY, 3, 0, 0, 0));
    offer(cmd(OP_UPDATE, 5, 1000, 1, 0));
    offer(cmd(OP_DELETE, 6, 0, 0, 0));
    offer(cmd(OP_RSVD_A, 15, '1, 1, '1));
    offer(cmd(OP_RSVD_A + 3'(1), 0, 0, 0, 0));
    offer(cmd(OP_RSVD_A + 3'(2), 9, 77, 1, 12));
    offer(cmd(OP_INSERT, 0, 0, 0, 0));
    offer(cmd(OP_INSERT, 15, '1, 1, 0));
    offer(cmd(OP_TICK, 0, 0, 0, '1));
    offer(cmd(OP_UPDATE, 5, 10, 1, 0));
    offer(cmd(OP_QUERY, 5, 0, 0, 0));
    offer(cmd(OP_QUERY, 15, 0, 0, 0));
    offer(cmd(OP_UPDATE, 0, 5, 0, 0));
    offer(cmd(OP_TICK, 0, 0, 0, '1));
    offer(cmd(OP_QUERY, 0, 0, 0, 0));
    offer(cmd(OP_QUERY, 15, 0, 0, 0));
    offer(cmd(OP_DELETE, 15, 0, 0, 0));
    offer(cmd(OP_QUERY, 15, 0, 0, 0));
    offer(cmd(OP_DELETE, 15, 0, 0, 0));
    offer(cmd(OP_INSERT, 7, 3, 0, 0));
    offer(cmd(OP_TICK, 0, 0, 0, 3));
    offer(cmd(OP_QUERY, 7, 0, 0, 0));

    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    repeat (150) offer(random_cmd());
    drain();

    tx_gaps = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      offer(cmd(OP_INSERT, SLOT_FIELD_W'(i), PERIOD_W'($urandom_range(0, 40)), 1, 0));
    end
    repeat (24) begin
      if ($urandom_range(0, 99) < 25) begin
        offer(cmd(OP_QUERY, SLOT_FIELD_W'($urandom_range(0, SLOTS - 1)), 0, 0, 0));
      end else begin
        offer(cmd(OP_TICK, 0, 0, 0, ELAPSED_W'($urandom_range(0, 60))));
      end
    end

    tx_gaps = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      offer(cmd(OP_INSERT, SLOT_FIELD_W'(i), 0, 0, 0));
    end
    offer(cmd(OP_TICK, 0, 0, 0, ELAPSED_W'($urandom_range(0, 10))));
    repeat (150) offer(random_cmd());

    drain();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
